// ----- sv/audio_mix_limiter_dac_defines.svh -----
// ----------------------------------------------------------------------------
// audio mix limiter dac assertion macros
// shared property shorthands, clocked on clk and quiet during rst
// ----------------------------------------------------------------------------
`ifndef AUDIO_MIX_LIMITER_DAC_DEFINES_SVH
`define AUDIO_MIX_LIMITER_DAC_DEFINES_SVH

// same-cycle implication
`define AML_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define AML_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/aml_pkg.sv -----
// ----------------------------------------------------------------------------
// aml_pkg
// widths, limiter constants and shared types of the mix limiter
// ----------------------------------------------------------------------------
package aml_pkg;

  localparam int VOLUME_LEVEL_BITS = 2;
  localparam int DAC_MIDSCALE      = 2048;

  localparam int SAMPLE_W = 16;
  localparam int ACC_W    = 24;
  localparam int FACTOR_W = 5;
  localparam int GAIN_W   = 20;
  localparam int SHIFT_W  = 4;
  localparam int DAC_W    = 16;
  localparam int FRAC_W   = 16;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = GAIN_W;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_START_GAIN  = 1'b0,
    REG_EXTRA_SHIFT = 1'b1
  } cfg_reg_t;

  // sample * factor and the raw sum
  localparam int PROD_FULL_W = SAMPLE_W + FACTOR_W + 1;
  localparam int PROD_W      = SAMPLE_W + FACTOR_W;
  localparam int RAW_W       = ACC_W + 1;

  // limiter thresholds
  localparam int TOP     = 32767 * (1 << VOLUME_LEVEL_BITS);
  localparam int BOT_MAG = 32768 * (1 << VOLUME_LEVEL_BITS);
  localparam logic signed [RAW_W-1:0] RAW_TOP = RAW_W'(TOP);
  localparam logic signed [RAW_W-1:0] RAW_BOT = RAW_W'(-BOT_MAG);

  // divider: numerator high part, divisor 2*|raw|, quotient below 0.5 in q4.16
  localparam int NUM_W     = $clog2(BOT_MAG + 1);
  localparam int DEN_W     = RAW_W;
  localparam int QUO_W     = FRAC_W;
  localparam int DIV_CNT_W = $clog2(QUO_W);

  localparam logic [GAIN_W-1:0] GAIN_ONE  = GAIN_W'(65536);
  localparam logic [GAIN_W-1:0] GAIN_STEP = GAIN_W'(102);
  localparam logic [GAIN_W-1:0] CLIP_GAIN_LIMIT = GAIN_W'((1 << (QUO_W - 1)) + 102);

  // gain multiply and the sum ahead of saturation
  localparam int MPY_W = PROD_W + GAIN_W + 1;
  localparam int SUM_W = MPY_W - FRAC_W + 1;
  localparam logic signed [SUM_W-1:0] MIX_MAX = SUM_W'((1 << (ACC_W - 1)) - 1);
  localparam logic signed [SUM_W-1:0] MIX_MIN = SUM_W'(-(1 << (ACC_W - 1)));

  localparam int DAC_BASE_SHIFT = 4;
  localparam int SHAMT_W        = SHIFT_W + 1;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } aml_div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [QUO_W-1:0] quo;
  } aml_div_rsp_t;

endpackage

// ----- sv/aml_item_if.sv -----
// ----------------------------------------------------------------------------
// aml_item_if
// input channel: one sample word with its slot value and mix factor
// ----------------------------------------------------------------------------
interface aml_item_if;
  import aml_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic signed [ACC_W-1:0]    accumulator;
  logic [FACTOR_W-1:0]        mix_factor;
  logic                       last_in_block;

  modport source (output valid, sample, accumulator, mix_factor, last_in_block,
                  input ready);
  modport sink (input valid, sample, accumulator, mix_factor, last_in_block,
                output ready);
endinterface

// ----- sv/aml_result_if.sv -----
// ----------------------------------------------------------------------------
// aml_result_if
// output channel: mixed slot value, dac code and flags
// ----------------------------------------------------------------------------
interface aml_result_if;
  import aml_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [ACC_W-1:0] mixed;
  logic [DAC_W-1:0]        dac_code;
  logic                    clipped;
  logic                    block_end;

  modport source (output valid, mixed, dac_code, clipped, block_end, input ready);
  modport sink (input valid, mixed, dac_code, clipped, block_end, output ready);
endinterface

// ----- sv/audio_mix_limiter_dac.sv -----
// ----------------------------------------------------------------------------
// audio_mix_limiter_dac
// mixes a sample into a buffer slot through an adaptive limiter gain
// ----------------------------------------------------------------------------
// One word in, one word out. Each word is handled on its own: item.ready is
// high only while the sequencer is idle, and the result sits in an output
// register so the next word can come in while it waits to be taken. A word
// that stays inside the limits goes straight from the check to the gain step;
// a word that clips first runs the 16-step restoring divider to work out the
// new gain (top or |bottom| over 2*|raw|, in q4.16). The divider is the loop
// that sets the rate; the rest is the gain recovery step, one multiplier pass
// and the sum, saturate and output register steps. The gain carries from word
// to word, recovers by 102/65536 per word while below 1.0, is loaded with 1.0
// on reset and is loaded from start_gain on every write of that register.
`include "audio_mix_limiter_dac_defines.svh"

module audio_mix_limiter_dac (
  input  logic                            clk,
  input  logic                            rst,
  aml_item_if.sink                        item,
  aml_result_if.source                    result,
  input  logic                            cfg_we,
  input  logic [aml_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [aml_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import aml_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,   // waiting for a word
    S_CHECK,  // compare raw sum to the limits, kick the divider on a clip
    S_DIV,    // divider running
    S_GAIN,   // gain recovery step
    S_MUL,    // product * gain
    S_SUM,    // add slot value, floor of the scaled product
    S_SAT,    // round toward zero and saturate
    S_OUT     // load the output register
  } state_t;

  state_t state;

  // configuration and running gain
  logic [GAIN_W-1:0]  gain;
  logic [SHIFT_W-1:0] extra_shift;

  // per-word working registers
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [RAW_W-1:0]  raw_r;
  logic                     clip_r;
  logic                     last_r;
  logic signed [MPY_W-1:0]  mpy_r;
  logic signed [SUM_W-1:0]  flr_r;
  logic                     frac_nz_r;
  logic signed [ACC_W-1:0]  mixed_r;

  // output register
  logic                    res_valid;
  logic signed [ACC_W-1:0] res_mixed;
  logic [DAC_W-1:0]        res_dac;
  logic                    res_clip;
  logic                    res_end;

  // combinational helpers
  logic signed [PROD_FULL_W-1:0] prod_full;
  logic signed [PROD_W-1:0]      prod_next;
  logic signed [RAW_W-1:0]       raw_next;
  logic signed [RAW_W-1:0]       raw_mag;
  logic                          over_top;
  logic                          under_bot;
  logic signed [SUM_W-1:0]       flr_next;
  logic signed [SUM_W-1:0]       trunc_v;
  logic signed [ACC_W-1:0]       sat_v;
  logic [SHAMT_W-1:0]            shamt;
  logic signed [ACC_W-1:0]       dac_shifted;
  logic [DAC_W-1:0]              dac_next;
  logic                          out_free;

  aml_div_req_t div_req;
  aml_div_rsp_t div_rsp;

  // sample * factor, then raw sum against the slot value
  assign prod_full = $signed(item.sample) * $signed({1'b0, item.mix_factor});
  assign prod_next = prod_full[PROD_W-1:0];
  assign raw_next  = RAW_W'(item.accumulator) + RAW_W'(prod_next);

  assign over_top  = raw_r > RAW_TOP;
  assign under_bot = raw_r < RAW_BOT;
  assign raw_mag   = raw_r[RAW_W-1] ? -raw_r : raw_r;

  // divider gets top or |bottom| over 2*|raw|
  assign div_req.start = (state == S_CHECK) && (over_top || under_bot);
  assign div_req.num   = raw_r[RAW_W-1] ? NUM_W'(BOT_MAG) : NUM_W'(TOP);
  assign div_req.den   = {raw_mag[RAW_W-2:0], 1'b0};

  aml_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // floor of (acc*65536 + mpy) / 65536; low product bits decide the round
  assign flr_next = SUM_W'(acc_r) + SUM_W'($signed(mpy_r[MPY_W-1:FRAC_W]));
  assign trunc_v  = flr_r + SUM_W'(flr_r[SUM_W-1] && frac_nz_r);

  always_comb begin
    if (trunc_v > MIX_MAX) begin
      sat_v = {1'b0, {(ACC_W-1){1'b1}}};
    end else if (trunc_v < MIX_MIN) begin
      sat_v = {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      sat_v = trunc_v[ACC_W-1:0];
    end
  end

  // dac code: arithmetic shift plus midscale, low bits only
  assign shamt       = SHAMT_W'(DAC_BASE_SHIFT) + SHAMT_W'(extra_shift);
  assign dac_shifted = mixed_r >>> shamt;
  assign dac_next    = DAC_W'(dac_shifted) + DAC_W'(DAC_MIDSCALE);

  assign out_free = !res_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      gain        <= GAIN_ONE;
      extra_shift <= '0;
      res_valid   <= 1'b0;
    end else begin
      // a word taken while the next one loads leaves valid set by S_OUT
      if (res_valid && result.ready && (state != S_OUT)) begin
        res_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (item.valid) begin
            acc_r  <= item.accumulator;
            prod_r <= prod_next;
            raw_r  <= raw_next;
            last_r <= item.last_in_block;
            state  <= S_CHECK;
          end
        end
        S_CHECK: begin
          clip_r <= over_top || under_bot;
          state  <= (over_top || under_bot) ? S_DIV : S_GAIN;
        end
        S_DIV: begin
          if (div_rsp.done) begin
            gain  <= GAIN_W'(div_rsp.quo);
            state <= S_GAIN;
          end
        end
        S_GAIN: begin
          if (gain < GAIN_ONE) begin
            gain <= gain + GAIN_STEP;
          end
          state <= S_MUL;
        end
        S_MUL: begin
          mpy_r <= prod_r * $signed({1'b0, gain});
          state <= S_SUM;
        end
        S_SUM: begin
          flr_r     <= flr_next;
          frac_nz_r <= |mpy_r[FRAC_W-1:0];
          state     <= S_SAT;
        end
        S_SAT: begin
          mixed_r <= sat_v;
          state   <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            res_mixed <= mixed_r;
            res_dac   <= dac_next;
            res_clip  <= clip_r;
            res_end   <= last_r;
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      // register writes; a start_gain write reloads the running gain
      if (cfg_we) begin
        unique case (cfg_index)
          REG_START_GAIN:  gain        <= cfg_data[GAIN_W-1:0];
          REG_EXTRA_SHIFT: extra_shift <= cfg_data[SHIFT_W-1:0];
          default:         gain        <= gain;
        endcase
      end
    end
  end

  assign item.ready       = (state == S_IDLE);
  assign result.valid     = res_valid;
  assign result.mixed     = res_mixed;
  assign result.dac_code  = res_dac;
  assign result.clipped   = res_clip;
  assign result.block_end = res_end;

  // divider only finishes while the sequencer waits on it
  `AML_ASSERT_IMP(a_div_done_in_div, div_rsp.done, state == S_DIV,
    "divider finished outside the divide step")

  // a clip gain is below one half, plus at most one recovery step
  `AML_ASSERT_IMP(a_clip_gain_low,
    (state == S_MUL) && clip_r && !$past(cfg_we) && !$past(cfg_we, 2),
    gain < CLIP_GAIN_LIMIT, "clip gain out of range")

  // writing start_gain loads the running gain
  `AML_ASSERT_NXT(a_start_gain_load, cfg_we && (cfg_index == REG_START_GAIN),
    gain == $past(cfg_data), "start_gain write did not load gain")

endmodule

// ----- sv/aml_div.sv -----
// ----------------------------------------------------------------------------
// aml_div
// restoring divider, one quotient bit per cycle over a shared subtractor
// ----------------------------------------------------------------------------
module aml_div (
  input  logic                  clk,
  input  logic                  rst,
  input  aml_pkg::aml_div_req_t req,
  output aml_pkg::aml_div_rsp_t rsp
);
  import aml_pkg::*;

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DEN_W-1:0]     rem;
  logic [DEN_W-1:0]     den_r;
  logic [QUO_W-1:0]     quo;

  logic [DEN_W:0] rem_sh;
  logic [DEN_W:0] diff;
  logic           take;

  // remainder stays below the divisor, so the shifted value fits one extra bit
  assign rem_sh = {rem, 1'b0};
  assign diff   = rem_sh - {1'b0, den_r};
  assign take   = !diff[DEN_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(QUO_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // the low numerator bits are all zero, so only zeros shift in
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem   <= DEN_W'(req.num);
      den_r <= req.den;
      quo   <= '0;
    end else if (busy) begin
      rem <= take ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      quo <= {quo[QUO_W-2:0], take};
    end
  end

  assign rsp = '{busy: busy, done: done, quo: quo};

endmodule

// ----- test/tb_audio_mix_limiter_dac.sv -----
// ----------------------------------------------------------------------------
// tb_audio_mix_limiter_dac
// self-checking bench for the mix limiter: a directed set of edge words, then
// random words under several gain and shift settings, with random idling on
// both channels. A scoreboard class predicts every result word and compares
// it field by field with what the block returns.
// ----------------------------------------------------------------------------
module tb_audio_mix_limiter_dac;
  import aml_pkg::*;

  // limiter thresholds and gain constants, q4.16
  localparam longint LIM_TOP      = longint'(32767) << VOLUME_LEVEL_BITS;
  localparam longint LIM_BOT_MAG  = longint'(32768) << VOLUME_LEVEL_BITS;
  localparam longint UNITY_GAIN   = 65536;
  localparam longint RECOVER_STEP = 102;
  localparam longint MIX_TOP      = 8388607;
  localparam longint MIX_BOTTOM   = -8388608;
  localparam int     DAC_BASE     = 4;

  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASES         = 6;
  localparam int PHASE_WORDS    = 250;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic signed [ACC_W-1:0]    accumulator;
    logic [FACTOR_W-1:0]        mix_factor;
    logic                       last_in_block;
  } mix_word_t;

  typedef struct {
    logic signed [ACC_W-1:0] mixed;
    logic [DAC_W-1:0]        dac_code;
    logic                    clipped;
    logic                    block_end;
  } mix_out_t;

  // ---------------------------------------------------------------------------
  // scoreboard: own copy of the gain state and registers, queue of expected
  // result words in acceptance order
  // ---------------------------------------------------------------------------
  class mix_scoreboard;
    logic [GAIN_W-1:0]  start_gain;
    logic [SHIFT_W-1:0] extra_shift;
    logic [GAIN_W-1:0]  gain;
    mix_out_t           pending_mix[$];
    int                 errors;
    int                 checked;
    int                 clipped_seen;
    int                 ends_seen;

    function new();
      start_gain   = GAIN_W'(UNITY_GAIN);
      extra_shift  = '0;
      gain         = GAIN_W'(UNITY_GAIN);
      errors       = 0;
      checked      = 0;
      clipped_seen = 0;
      ends_seen    = 0;
    endfunction

    // a start_gain write also reloads the running gain
    function void load_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_START_GAIN: begin
          start_gain = data[GAIN_W-1:0];
          gain       = data[GAIN_W-1:0];
        end
        REG_EXTRA_SHIFT: extra_shift = data[SHIFT_W-1:0];
        default: ;
      endcase
    endfunction

    function mix_out_t predict_mix(mix_word_t w);
      longint   prod;
      longint   raw;
      longint   total;
      longint   mag;
      longint   q;
      longint   dac;
      mix_out_t r;
      prod = longint'(w.sample) * longint'(w.mix_factor);
      raw  = longint'(w.accumulator) + prod;
      r.clipped = 1'b0;
      if (raw > LIM_TOP) begin
        r.clipped = 1'b1;
        gain = GAIN_W'((LIM_TOP <<< FRAC_W) / (2 * raw));
      end else if (raw < -LIM_BOT_MAG) begin
        r.clipped = 1'b1;
        gain = GAIN_W'((LIM_BOT_MAG <<< FRAC_W) / (-2 * raw));
      end
      // slow recovery toward unity
      if (longint'(gain) < UNITY_GAIN) gain = GAIN_W'(longint'(gain) + RECOVER_STEP);
      total = longint'(w.accumulator) * UNITY_GAIN + prod * longint'(gain);
      // truncate toward zero, then saturate
      mag = (total < 0) ? -total : total;
      q   = mag >> FRAC_W;
      if (total < 0) q = -q;
      if (q > MIX_TOP) q = MIX_TOP;
      if (q < MIX_BOTTOM) q = MIX_BOTTOM;
      r.mixed     = q[ACC_W-1:0];
      dac         = (q >>> (DAC_BASE + int'(extra_shift))) + DAC_MIDSCALE;
      r.dac_code  = dac[DAC_W-1:0];
      r.block_end = w.last_in_block;
      return r;
    endfunction

    function void note_word(mix_word_t w);
      mix_out_t r;
      r = predict_mix(w);
      pending_mix.push_back(r);
      if (r.clipped) clipped_seen++;
      if (r.block_end) ends_seen++;
    endfunction

    function void compare_field(string fname, logic [ACC_W-1:0] want, logic [ACC_W-1:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s expected 0x%0h actual 0x%0h", $time, fname, want, got);
      end
    endfunction

    function void check_word(mix_out_t got);
      mix_out_t want;
      if (pending_mix.size() == 0) begin
        errors++;
        $display("%0t: result word with nothing outstanding, mixed 0x%0h", $time, got.mixed);
        return;
      end
      want = pending_mix.pop_front();
      checked++;
      compare_field("mixed", want.mixed, got.mixed);
      compare_field("dac_code", ACC_W'(want.dac_code), ACC_W'(got.dac_code));
      compare_field("clipped", ACC_W'(want.clipped), ACC_W'(got.clipped));
      compare_field("block_end", ACC_W'(want.block_end), ACC_W'(got.block_end));
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // clock, reset, channels and the block
  // ---------------------------------------------------------------------------
  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_we;
  cfg_reg_t               cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  aml_item_if   item_ch ();
  aml_result_if result_ch ();

  audio_mix_limiter_dac uut (
    .clk       (clk),
    .rst       (rst),
    .item      (item_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  mix_scoreboard mix_sb;

  // idling knobs, changed per phase
  bit tx_idle_on;
  bit rx_idle_on;
  int rx_stall_left;
  int quiet_cycles = 0;
  int settings_used = 0;

  // mostly back to back, some short gaps, now and then a long one
  function automatic int random_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // result side: ready changes on the falling edge only
  always @(negedge clk) begin
    if (rx_stall_left > 0) begin
      result_ch.ready = 1'b0;
      rx_stall_left--;
    end else begin
      result_ch.ready = 1'b1;
      if (rx_idle_on) rx_stall_left = random_gap();
    end
  end

  // every result word taken is checked against the oldest prediction
  always @(posedge clk) begin : take_result
    mix_out_t got;
    if (rst === 1'b0 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
      got.mixed     = result_ch.mixed;
      got.dac_code  = result_ch.dac_code;
      got.clipped   = result_ch.clipped;
      got.block_end = result_ch.block_end;
      mix_sb.check_word(got);
    end
  end

  // watchdog: too long without a handshake on either channel
  always @(posedge clk) begin
    if ((item_ch.valid === 1'b1 && item_ch.ready === 1'b1) ||
        (result_ch.valid === 1'b1 && result_ch.ready === 1'b1))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // driving tasks, all entered and left on a falling edge
  // ---------------------------------------------------------------------------
  function automatic mix_word_t make_word(int s, int a, int f, bit last);
    mix_word_t w;
    w.sample        = s[SAMPLE_W-1:0];
    w.accumulator   = a[ACC_W-1:0];
    w.mix_factor    = f[FACTOR_W-1:0];
    w.last_in_block = last;
    return w;
  endfunction

  // valid stays high from word to word unless a gap is drawn
  task automatic send_word(mix_word_t w);
    int gap;
    gap = tx_idle_on ? random_gap() : 0;
    if (gap > 0) begin
      item_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_ch.sample        = w.sample;
    item_ch.accumulator   = w.accumulator;
    item_ch.mix_factor    = w.mix_factor;
    item_ch.last_in_block = w.last_in_block;
    item_ch.valid         = 1'b1;
    @(posedge clk);
    while (item_ch.ready !== 1'b1) @(posedge clk);
    mix_sb.note_word(w);
    @(negedge clk);
  endtask

  // hold the sender until every result is back and the sequencer is idle
  task automatic wait_idle();
    item_ch.valid = 1'b0;
    while (mix_sb.pending_mix.size() != 0) @(negedge clk);
    while (item_ch.ready !== 1'b1) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    mix_sb.load_reg(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic apply_setting(logic [GAIN_W-1:0] g, logic [SHIFT_W-1:0] sh);
    write_reg(REG_START_GAIN, CFG_DATA_W'(g));
    write_reg(REG_EXTRA_SHIFT, CFG_DATA_W'(sh));
    settings_used++;
  endtask

  // random words: mostly program material that exercises clip and recovery,
  // the rest fully random fields
  function automatic mix_word_t random_word();
    mix_word_t w;
    int        pick;
    pick            = $urandom_range(0, 99);
    w.sample        = SAMPLE_W'($urandom);
    w.accumulator   = ACC_W'($urandom);
    w.mix_factor    = FACTOR_W'($urandom);
    w.last_in_block = ($urandom_range(0, 15) == 0);
    if (pick < 40) begin
      // ordinary material: moderate slot value, low factor
      w.accumulator = ACC_W'(int'($urandom_range(0, 200000)) - 100000);
      w.mix_factor  = FACTOR_W'($urandom_range(0, 4));
    end else if (pick < 60) begin
      // slot already close to one of the limits
      w.accumulator = ACC_W'(int'($urandom_range(0, 1) ? LIM_TOP : -LIM_BOT_MAG)
                             + int'($urandom_range(0, 128)) - 64);
      w.sample      = SAMPLE_W'(int'($urandom_range(0, 64)) - 32);
      w.mix_factor  = FACTOR_W'($urandom_range(0, 2));
    end else if (pick < 75) begin
      // loud source, high factor
      w.sample     = $urandom_range(0, 1) ? SAMPLE_W'($urandom_range(32000, 32767))
                                          : SAMPLE_W'(-int'($urandom_range(32000, 32768)));
      w.mix_factor = FACTOR_W'($urandom_range(16, 31));
    end
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    mix_sb = new();
    item_ch.valid         = 1'b0;
    item_ch.sample        = '0;
    item_ch.accumulator   = '0;
    item_ch.mix_factor    = '0;
    item_ch.last_in_block = 1'b0;
    result_ch.ready       = 1'b0;
    cfg_we                = 1'b0;
    cfg_index             = REG_START_GAIN;
    cfg_data              = '0;
    tx_idle_on            = 1'b0;
    rx_idle_on            = 1'b0;
    rx_stall_left         = 0;
    rst                   = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed words at reset settings (unity gain, no extra shift)
    send_word(make_word(0, 0, 0, 0));
    send_word(make_word(32767, 0, 1, 0));
    send_word(make_word(-32768, 0, 1, 1));
    // exactly on the limits, then one past each
    send_word(make_word(0, int'(LIM_TOP), 0, 0));
    send_word(make_word(0, int'(LIM_TOP) + 1, 0, 0));
    send_word(make_word(0, -int'(LIM_BOT_MAG), 0, 0));
    send_word(make_word(0, -int'(LIM_BOT_MAG) - 1, 0, 0));
    // factor above 16, both polarities
    send_word(make_word(32767, 0, 31, 0));
    send_word(make_word(-32768, 0, 31, 0));
    // mixed overflow at both rails
    send_word(make_word(32767, 8388607, 16, 0));
    send_word(make_word(-32768, -8388608, 16, 1));
    // small negatives: truncation toward zero and the arithmetic dac shift
    send_word(make_word(-1, 0, 1, 0));
    send_word(make_word(0, -1, 0, 0));
    // gain recovering across a block end
    send_word(make_word(1000, 500, 3, 1));
    send_word(make_word(-1000, -500, 3, 0));

    // full scale gain, widest shift
    wait_idle();
    apply_setting(GAIN_W'(20'hFFFFF), SHIFT_W'(15));
    send_word(make_word(32767, 0, 1, 0));
    send_word(make_word(-32768, 8388607, 1, 0));
    send_word(make_word(100, -100, 2, 1));
    send_word(make_word(32767, 0, 31, 0));

    // zero gain, shift 12
    wait_idle();
    apply_setting('0, SHIFT_W'(12));
    send_word(make_word(32767, 0, 16, 0));
    send_word(make_word(-32768, 1000, 16, 0));
    send_word(make_word(12345, -2000, 7, 1));

    // random phases; phase 1 runs without idling, phase 3 stalls only the sender
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      case (ph)
        0: apply_setting(GAIN_W'(UNITY_GAIN), '0);
        1: apply_setting(GAIN_W'(20'hFFFFF), SHIFT_W'(15));
        2: apply_setting('0, SHIFT_W'(12));
        3: apply_setting(GAIN_W'($urandom), SHIFT_W'($urandom));
        4: apply_setting(GAIN_W'($urandom_range(32768, 65535)),
                         SHIFT_W'($urandom_range(0, 15)));
        default: apply_setting(GAIN_W'($urandom), SHIFT_W'($urandom));
      endcase
      tx_idle_on = (ph != 1);
      rx_idle_on = (ph != 1) && (ph != 3);
      for (int i = 0; i < PHASE_WORDS; i++) begin
        // mid-phase the sender holds off until the result side has drained
        if (i == PHASE_WORDS / 2) wait_idle();
        send_word(random_word());
      end
    end

    wait_idle();
    $display("checked %0d result words: %0d clipping, %0d block ends",
             mix_sb.checked, mix_sb.clipped_seen, mix_sb.ends_seen);
    $display("%0d gain/shift settings, gain loads from zero to full scale, shifts 0 to 15",
             settings_used);
    if (mix_sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", mix_sb.errors);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
